// ===== hdl/ctss_pkg.sv =====
`timescale 1ns / 1ps

package ctss_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [23:0] start_offset;
        logic [15:0] token_length;
        logic [7:0]  bad_char;
        logic        final_token;
    } t_out_item;

    // Up to three tokens leave the scanner for one source byte.
    typedef struct packed {
        logic [1:0]           count;
        t_out_item [2:0]      item;
    } t_result_set;

    localparam int QUEUE_DEPTH    = 8;
    localparam int QUEUE_PTR_BITS = 3;
    localparam int QUEUE_CNT_BITS = 4;
    localparam int MAX_RESULTS    = 3;

    localparam logic [5:0] K_NUMBER   = 6'd0;
    localparam logic [5:0] K_IDENT    = 6'd1;
    localparam logic [5:0] K_KEYWORD0 = 6'd2;
    localparam logic [5:0] K_SEMI     = 6'd20;
    localparam logic [5:0] K_PLUS     = 6'd28;
    localparam logic [5:0] K_MINUS    = 6'd30;
    localparam logic [5:0] K_EQUAL    = 6'd32;
    localparam logic [5:0] K_END      = 6'd34;
    localparam logic [5:0] K_ERROR    = 6'd35;

    localparam int KW_COUNT = 18;

    // Keywords packed first byte in the low bits, zero padded.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_6469_6F76,  // void
        64'h0000_0000_0074_6E69,  // int
        64'h0000_0000_7261_6863,  // char
        64'h0000_0074_726F_6873,  // short
        64'h0000_0000_676E_6F6C,  // long
        64'h0000_0074_616F_6C66,  // float
        64'h0000_656C_6275_6F64,  // double
        64'h0000_6465_6E67_6973,  // signed
        64'h6465_6E67_6973_6E75,  // unsigned
        64'h0000_0074_736E_6F63,  // const
        64'h656C_6974_616C_6F76,  // volatile
        64'h7463_6972_7473_6572,  // restrict
        64'h0000_6369_7461_7473,  // static
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6573_6C65,  // else
        64'h0000_0000_0072_6F66,  // for
        64'h0000_0065_6C69_6877,  // while
        64'h0000_6E72_7574_6572   // return
    };

    function automatic logic [5:0] kw_kind(input logic [63:0] kw_buf, input logic fits);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (fits && kw_buf == KW_TEXT[i]) begin
                kind = K_KEYWORD0 + 6'(i);
            end
        end
        return kind;
    endfunction

endpackage

// ===== hdl/ctss_core.sv =====
`timescale 1ns / 1ps

module ctss_core #(
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  ctss_pkg::t_in_item    i_item,
    output ctss_pkg::t_result_set o_set
);

    localparam logic [2:0] M_IDLE     = 3'd0;
    localparam logic [2:0] M_NUMBER   = 3'd1;
    localparam logic [2:0] M_NUM_DOT  = 3'd2;
    localparam logic [2:0] M_FRACTION = 3'd3;
    localparam logic [2:0] M_IDENT    = 3'd4;
    localparam logic [2:0] M_PUNCT    = 3'd5;
    localparam logic [2:0] M_ERROR    = 3'd6;

    localparam int SUM_BITS = ((OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS) + 1;

    logic [2:0]             r_mode;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_start;
    logic [LENGTH_BITS-1:0] r_len;
    logic [63:0]            r_kwbuf;
    logic [7:0]             r_pend;

    logic [2:0]             n_mode;
    logic [OFFSET_BITS-1:0] n_start;
    logic [LENGTH_BITS-1:0] n_len;
    logic [63:0]            n_kwbuf;
    logic [7:0]             n_pend;

    logic [7:0]  c;
    logic        eos;
    logic        is_dig;
    logic        is_alpha;
    logic        is_ws;
    logic        is_pm;
    logic        sp_hit;
    logic [5:0]  sp_kind;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [LENGTH_BITS-1:0] len_inc1;
    logic [LENGTH_BITS:0]   len_sum2;
    logic [LENGTH_BITS-1:0] len_inc2;
    logic [SUM_BITS-1:0]    cur_sum;
    logic [OFFSET_BITS-1:0] cur_err_off;
    logic [SUM_BITS-1:0]    nxt_sum;
    logic [OFFSET_BITS-1:0] nxt_err_off;
    logic [5:0]             cur_ident;
    logic [5:0]             nxt_ident;

    ctss_pkg::t_out_item [2:0] s_items;
    logic [1:0]                s_cnt;

    function automatic ctss_pkg::t_out_item mk(
        input logic [5:0]             kind,
        input logic [OFFSET_BITS-1:0] start,
        input logic [LENGTH_BITS-1:0] len,
        input logic [7:0]             bad,
        input logic                   fin
    );
        logic [OFFSET_BITS+23:0] s_wide;
        logic [LENGTH_BITS+15:0] l_wide;
        ctss_pkg::t_out_item     t;
        s_wide         = {24'b0, start};
        l_wide         = {16'b0, len};
        t.token_kind   = kind;
        t.start_offset = s_wide[23:0];
        t.token_length = l_wide[15:0];
        t.bad_char     = bad;
        t.final_token  = fin;
        return t;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] pend);
        logic [5:0] kind;
        if (pend == 8'h2B) begin
            kind = ctss_pkg::K_PLUS;
        end else if (pend == 8'h2D) begin
            kind = ctss_pkg::K_MINUS;
        end else begin
            kind = ctss_pkg::K_EQUAL;
        end
        return kind;
    endfunction

    assign c   = i_item.char_code;
    assign eos = i_item.end_of_source;

    assign is_dig   = (c >= 8'h30) && (c <= 8'h39);
    assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                      || (c == 8'h5F);
    assign is_ws    = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h00);
    assign is_pm    = (c == 8'h2B) || (c == 8'h2D) || (c == 8'h3D);

    always_comb begin
        sp_hit  = 1'b1;
        sp_kind = ctss_pkg::K_SEMI;
        case (c)
            8'h3B:   sp_kind = ctss_pkg::K_SEMI;
            8'h28:   sp_kind = ctss_pkg::K_SEMI + 6'd1;
            8'h29:   sp_kind = ctss_pkg::K_SEMI + 6'd2;
            8'h7B:   sp_kind = ctss_pkg::K_SEMI + 6'd3;
            8'h7D:   sp_kind = ctss_pkg::K_SEMI + 6'd4;
            8'h7E:   sp_kind = ctss_pkg::K_SEMI + 6'd5;
            8'h2A:   sp_kind = ctss_pkg::K_SEMI + 6'd6;
            8'h2F:   sp_kind = ctss_pkg::K_SEMI + 6'd7;
            default: sp_hit  = 1'b0;
        endcase
    end

    // Saturating counters and offsets.
    assign pos_inc  = (r_pos == {OFFSET_BITS{1'b1}}) ? r_pos : r_pos + 1'b1;
    assign len_inc1 = (r_len == {LENGTH_BITS{1'b1}}) ? r_len : r_len + 1'b1;
    assign len_sum2 = {1'b0, r_len} + (LENGTH_BITS+1)'(2);
    assign len_inc2 = len_sum2[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : len_sum2[LENGTH_BITS-1:0];

    assign cur_sum     = SUM_BITS'(r_start) + SUM_BITS'(r_len);
    assign cur_err_off = (cur_sum > SUM_BITS'({OFFSET_BITS{1'b1}})) ? {OFFSET_BITS{1'b1}}
                                                                   : cur_sum[OFFSET_BITS-1:0];
    assign nxt_sum     = SUM_BITS'(n_start) + SUM_BITS'(n_len);
    assign nxt_err_off = (nxt_sum > SUM_BITS'({OFFSET_BITS{1'b1}})) ? {OFFSET_BITS{1'b1}}
                                                                   : nxt_sum[OFFSET_BITS-1:0];

    assign cur_ident = ctss_pkg::kw_kind(r_kwbuf, r_len <= LENGTH_BITS'(8));
    assign nxt_ident = ctss_pkg::kw_kind(n_kwbuf, n_len <= LENGTH_BITS'(8));

    // Scan the byte against the open token.
    always_comb begin
        logic do_start;
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_kwbuf  = r_kwbuf;
        n_pend   = r_pend;
        s_items  = '0;
        s_cnt    = 2'd0;
        do_start = 1'b0;
        case (r_mode)
            M_IDLE: begin
                do_start = 1'b1;
            end
            M_NUMBER, M_FRACTION: begin
                if (is_dig) begin
                    n_len = len_inc1;
                end else if (r_mode == M_NUMBER && c == 8'h2E) begin
                    n_mode = M_NUM_DOT;
                end else begin
                    s_items[s_cnt] = mk(ctss_pkg::K_NUMBER, r_start, r_len, 8'h00, 1'b0);
                    s_cnt          = s_cnt + 2'd1;
                    do_start       = 1'b1;
                end
            end
            M_NUM_DOT: begin
                if (is_dig) begin
                    n_len  = len_inc2;
                    n_mode = M_FRACTION;
                end else begin
                    // Dot without a digit: close the number, flag the dot.
                    s_items[0] = mk(ctss_pkg::K_NUMBER, r_start, r_len, 8'h00, 1'b0);
                    s_items[1] = mk(ctss_pkg::K_ERROR, cur_err_off, LENGTH_BITS'(1),
                                    8'h2E, 1'b1);
                    s_cnt      = 2'd2;
                    n_mode     = M_ERROR;
                end
            end
            M_IDENT: begin
                if (is_alpha || is_dig) begin
                    if (r_len < LENGTH_BITS'(8)) begin
                        n_kwbuf[{r_len[2:0], 3'b000} +: 8] = c;
                    end
                    n_len = len_inc1;
                end else begin
                    s_items[s_cnt] = mk(cur_ident, r_start, r_len, 8'h00, 1'b0);
                    s_cnt          = s_cnt + 2'd1;
                    do_start       = 1'b1;
                end
            end
            M_PUNCT: begin
                if (c == r_pend) begin
                    s_items[s_cnt] = mk(punct_kind(r_pend) + 6'd1, r_start,
                                        LENGTH_BITS'(2), 8'h00, 1'b0);
                    s_cnt          = s_cnt + 2'd1;
                    n_mode         = M_IDLE;
                end else begin
                    s_items[s_cnt] = mk(punct_kind(r_pend), r_start, LENGTH_BITS'(1),
                                        8'h00, 1'b0);
                    s_cnt          = s_cnt + 2'd1;
                    do_start       = 1'b1;
                end
            end
            default: begin
                // Error mode drops every byte.
            end
        endcase

        if (do_start) begin
            n_mode = M_IDLE;
            if (!is_ws) begin
                n_start = r_pos;
                n_len   = LENGTH_BITS'(1);
                if (is_dig) begin
                    n_mode = M_NUMBER;
                end else if (is_alpha) begin
                    n_mode  = M_IDENT;
                    n_kwbuf = {56'b0, c};
                end else if (is_pm) begin
                    n_mode = M_PUNCT;
                    n_pend = c;
                end else if (sp_hit) begin
                    s_items[s_cnt] = mk(sp_kind, r_pos, LENGTH_BITS'(1), 8'h00, 1'b0);
                    s_cnt          = s_cnt + 2'd1;
                end else begin
                    n_mode         = M_ERROR;
                    s_items[s_cnt] = mk(ctss_pkg::K_ERROR, r_pos, LENGTH_BITS'(1), c, 1'b1);
                    s_cnt          = s_cnt + 2'd1;
                end
            end
        end
    end

    // On the last byte flush the open token and close the stream.
    always_comb begin
        ctss_pkg::t_out_item [2:0] f_items;
        logic [1:0]                f_cnt;
        f_items = s_items;
        f_cnt   = s_cnt;
        if (eos) begin
            case (n_mode)
                M_NUMBER, M_FRACTION: begin
                    f_items[f_cnt] = mk(ctss_pkg::K_NUMBER, n_start, n_len, 8'h00, 1'b0);
                    f_cnt          = f_cnt + 2'd1;
                end
                M_NUM_DOT: begin
                    f_items[f_cnt] = mk(ctss_pkg::K_NUMBER, n_start, n_len, 8'h00, 1'b0);
                    f_cnt          = f_cnt + 2'd1;
                    f_items[f_cnt] = mk(ctss_pkg::K_ERROR, nxt_err_off, LENGTH_BITS'(1),
                                        8'h2E, 1'b1);
                    f_cnt          = f_cnt + 2'd1;
                end
                M_IDENT: begin
                    f_items[f_cnt] = mk(nxt_ident, n_start, n_len, 8'h00, 1'b0);
                    f_cnt          = f_cnt + 2'd1;
                end
                M_PUNCT: begin
                    f_items[f_cnt] = mk(punct_kind(n_pend), n_start, LENGTH_BITS'(1),
                                        8'h00, 1'b0);
                    f_cnt          = f_cnt + 2'd1;
                end
                default: begin
                end
            endcase
            if (n_mode != M_ERROR && n_mode != M_NUM_DOT) begin
                f_items[f_cnt] = mk(ctss_pkg::K_END, pos_inc, '0, 8'h00, 1'b1);
                f_cnt          = f_cnt + 2'd1;
            end
        end
        o_set.item  = f_items;
        o_set.count = f_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_kwbuf <= '0;
            r_pend  <= '0;
        end else if (i_fire) begin
            if (eos) begin
                r_mode  <= M_IDLE;
                r_pos   <= '0;
                r_start <= '0;
                r_len   <= '0;
                r_kwbuf <= '0;
                r_pend  <= '0;
            end else begin
                r_mode  <= n_mode;
                r_pos   <= pos_inc;
                r_start <= n_start;
                r_len   <= n_len;
                r_kwbuf <= n_kwbuf;
                r_pend  <= n_pend;
            end
        end
    end

endmodule

// ===== hdl/ctss_queue.sv =====
`timescale 1ns / 1ps

module ctss_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ctss_pkg::t_result_set i_set,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_stall,
    output ctss_pkg::t_out_item   o_item
);

    ctss_pkg::t_out_item r_mem [ctss_pkg::QUEUE_DEPTH];

    logic [ctss_pkg::QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [ctss_pkg::QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [ctss_pkg::QUEUE_CNT_BITS-1:0] r_count;

    logic [ctss_pkg::QUEUE_CNT_BITS-1:0] n_count;
    logic [1:0]                          push_cnt;
    logic                                pop;

    assign push_cnt = i_push ? i_set.count : 2'd0;
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && !i_stall;
    assign o_item   = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= ctss_pkg::QUEUE_CNT_BITS'(ctss_pkg::QUEUE_DEPTH
                                                          - ctss_pkg::MAX_RESULTS));
    assign n_count  = r_count + ctss_pkg::QUEUE_CNT_BITS'(push_cnt)
                      - ctss_pkg::QUEUE_CNT_BITS'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ctss_pkg::MAX_RESULTS; k++) begin
            if (2'(k) < push_cnt) begin
                r_mem[r_wr_ptr + ctss_pkg::QUEUE_PTR_BITS'(k)] <= i_set.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ctss_pkg::QUEUE_PTR_BITS'(push_cnt);
            r_rd_ptr <= r_rd_ptr + ctss_pkg::QUEUE_PTR_BITS'(pop);
            r_count  <= n_count;
        end
    end

endmodule

// ===== hdl/c_subset_token_scanner.sv =====
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register until the queue has room;
//   it is then scanned and its tokens are written into the token queue.
// Throughput: one byte per cycle while the eight-entry token queue has room for
//   three tokens; unstalled, tokens leave one per cycle; output rate sets the pace.
// Reset: synchronous, active low; returns the scanner to idle at offset zero
//   and empties the input register and the token queue.

module c_subset_token_scanner #(
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte side
    input  logic                i_valid,
    output logic                o_stall,
    input  ctss_pkg::t_in_item  i_item,
    // token side
    output logic                o_valid,
    input  logic                i_stall,
    output ctss_pkg::t_out_item o_item
);

    // Input register: holds one byte until the queue can absorb its tokens.
    logic               r_in_valid;
    ctss_pkg::t_in_item r_in;

    logic                  room;
    logic                  fire;
    ctss_pkg::t_result_set set;

    // Scan the held byte only when the queue can take the worst case of three.
    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset: take a new byte whenever the register frees up.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
    end

    // Scanner state and token formation for one byte.
    ctss_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_set   (set)
    );

    // Token queue: absorb up to three tokens per byte, drain one per cycle unless stalled.
    ctss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_set   (set),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
